// ===== rtl/uplink_contention_and_rr_scheduler_assert.svh =====
// assertion macros for the uplink scheduler
// both sample on the rising edge of clk and are off while rst is high
`ifndef UPLINK_CONTENTION_AND_RR_SCHEDULER_ASSERT_SVH
`define UPLINK_CONTENTION_AND_RR_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define URRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define URRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== rtl/urrs_pkg.sv =====
// ----------------------------------------------------------------------------
// urrs_pkg
// shared types and constants of the uplink contention resolver and scheduler
// ----------------------------------------------------------------------------
package urrs_pkg;

  localparam int PRE_W     = 6;
  localparam int BITS_W    = 32;
  localparam int BPB_W     = 16;
  localparam int BLK_W     = 7;
  localparam int ALLOC_W   = 23;
  localparam int MAX_BLOCKS = 110;

  // input operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // register indexes
  localparam logic REG_BITS_PER_BLOCK  = 1'b0;
  localparam logic REG_BLOCKS_PER_TICK = 1'b1;

  // result kinds
  localparam logic KIND_RESPONSE = 1'b0;
  localparam logic KIND_GRANT    = 1'b1;

  // entry handed around the ring during contention resolution
  typedef struct packed {
    logic             valid;
    logic [PRE_W-1:0] preamble;
  } ring_t;

  // broadcast commands from the controller to every cell
  typedef struct packed {
    logic req_wr;
    logic ring_load;
    logic ring_shift;
    logic resp_take;
    logic tick_start;
    logic tick_step;
    logic grant_take;
  } cell_cmd_t;

  // per-cell status seen by the controller
  typedef struct packed {
    logic             req_valid;
    logic             collided;
    logic             pending_nz;
    logic             token;
    logic [BLK_W-1:0] blocks;
  } cell_stat_t;

endpackage

// ===== rtl/urrs_cell.sv =====
// ----------------------------------------------------------------------------
// urrs_cell
// one UE slot: stored request, pending bits, block count, ring and token stage
// ----------------------------------------------------------------------------
module urrs_cell
  import urrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic              sel,
  input  logic [PRE_W-1:0]  preamble,
  input  logic [BITS_W-1:0] pending_bits,
  input  logic [BPB_W-1:0]  bits_per_block,
  input  ring_t             ring_in,
  output ring_t             ring_out,
  input  logic              token_in,
  output cell_stat_t        stat
);

  logic              req_valid;
  logic [PRE_W-1:0]  req_pre;
  logic [BITS_W-1:0] req_bits;
  logic [BITS_W-1:0] pending;
  logic [BLK_W-1:0]  blocks;
  logic              collided;
  logic              token;
  ring_t             ring;
  logic              serve;
  logic [BITS_W-1:0] bpb_ext;

  assign bpb_ext = {{(BITS_W-BPB_W){1'b0}}, bits_per_block};
  assign serve   = token && (pending != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      pending   <= '0;
      blocks    <= '0;
      token     <= 1'b0;
      collided  <= 1'b0;
      ring      <= '0;
    end else begin
      if (cmd.req_wr && sel) begin
        req_valid <= 1'b1;
      end
      if (cmd.ring_load) begin
        ring     <= '{valid: req_valid, preamble: req_pre};
        collided <= 1'b0;
      end
      if (cmd.ring_shift) begin
        ring <= ring_in;
        if (ring_in.valid && req_valid && (ring_in.preamble == req_pre)) begin
          collided <= 1'b1;
        end
      end
      if (cmd.resp_take && sel) begin
        req_valid <= 1'b0;
        if (!collided) begin
          pending <= req_bits;
        end
      end
      if (cmd.tick_start) begin
        token  <= sel;
        blocks <= '0;
      end
      if (cmd.tick_step) begin
        token <= token_in;
        if (serve) begin
          blocks  <= blocks + 1'b1;
          pending <= (pending > bpb_ext) ? (pending - bpb_ext) : '0;
        end
      end
      if (cmd.grant_take && sel) begin
        blocks <= '0;
      end
    end
  end

  // request payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.req_wr && sel) begin
      req_pre  <= preamble;
      req_bits <= pending_bits;
    end
  end

  assign ring_out = ring;
  assign stat     = '{req_valid: req_valid, collided: collided,
                      pending_nz: (pending != '0), token: token, blocks: blocks};

endmodule

// ===== rtl/uplink_contention_and_rr_scheduler.sv =====
// ----------------------------------------------------------------------------
// uplink_contention_and_rr_scheduler
// contention resolver and round robin resource block scheduler over a ring
// of per-UE cells
// ----------------------------------------------------------------------------
// request: stored in the addressed cell; resolve: ring walk, then a scan of the cells
// tick: one ring step per cycle until the blocks run out or no cell has bits, then a scan
// one item at a time; the ring walk and the result scan set the item time
// results leave from a registered output stage, one beat per cycle at most
// reset clears all stored requests, pending bits and block counts at once
// ----------------------------------------------------------------------------
module uplink_contention_and_rr_scheduler
  import urrs_pkg::*;
#(
  parameter int NUM_UE = 16   // 2 to 16, bounded by the ue_id width
)
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [3:0]          ue_id,
  input  logic [PRE_W-1:0]    preamble,
  input  logic [BITS_W-1:0]   pending_bits,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic [3:0]          ue_id_out,
  output logic                granted,
  output logic [ALLOC_W-1:0]  allocated_bits,
  output logic                last
);

`include "uplink_contention_and_rr_scheduler_assert.svh"

  localparam int IDX_W = $clog2(NUM_UE);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RING  = 5'b00010,
    ST_RESP  = 5'b00100,
    ST_TICK  = 5'b01000,
    ST_GRANT = 5'b10000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic [BLK_W-1:0]   blk_cnt;
  logic [BPB_W-1:0]   bits_per_block;
  logic [BLK_W-1:0]   blocks_per_tick;
  logic [BLK_W-1:0]   blk_limit;

  cell_cmd_t          cmd;
  logic [NUM_UE-1:0]  sel;
  ring_t              ring [NUM_UE];
  cell_stat_t         stat [NUM_UE];

  logic [NUM_UE-1:0]  req_valid_vec;
  logic [NUM_UE-1:0]  pending_vec;
  logic [NUM_UE-1:0]  token_vec;
  logic [NUM_UE-1:0]  served_vec;
  logic [NUM_UE-1:0]  blocks_vec;
  logic [NUM_UE-1:0]  later_vec;

  logic               accept;
  logic               slot_free;
  logic               scan_end;
  logic               out_load;
  logic               ue_in_range;
  cell_stat_t         cur;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_block  <= BPB_W'(1000);
      blocks_per_tick <= BLK_W'(25);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_BITS_PER_BLOCK:  bits_per_block  <= pwdata[BPB_W-1:0];
        REG_BLOCKS_PER_TICK: blocks_per_tick <= pwdata[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BITS_PER_BLOCK:  prdata = {{(32-BPB_W){1'b0}}, bits_per_block};
      REG_BLOCKS_PER_TICK: prdata = {{(32-BLK_W){1'b0}}, blocks_per_tick};
      default:             prdata = '0;
    endcase
  end

  // blocks per tick clamped to the carrier size
  assign blk_limit = (blocks_per_tick > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS)
                                                           : blocks_per_tick;

  // ---------------------------------------------------------------- cells
  genvar g;
  generate
    for (g = 0; g < NUM_UE; g++) begin : g_cell
      urrs_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .cmd            (cmd),
        .sel            (sel[g]),
        .preamble       (preamble),
        .pending_bits   (pending_bits),
        .bits_per_block (bits_per_block),
        .ring_in        (ring[(g + NUM_UE - 1) % NUM_UE]),
        .ring_out       (ring[g]),
        .token_in       (stat[(g + NUM_UE - 1) % NUM_UE].token),
        .stat           (stat[g])
      );
      assign req_valid_vec[g] = stat[g].req_valid;
      assign pending_vec[g]   = stat[g].pending_nz;
      assign token_vec[g]     = stat[g].token;
      assign served_vec[g]    = stat[g].token && stat[g].pending_nz;
      assign blocks_vec[g]    = (stat[g].blocks != '0);
      assign later_vec[g]     = (IDX_W'(g) > idx);
    end
  endgenerate

  // ---------------------------------------------------------------- control
  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign slot_free   = !out_valid || !out_stall;
  assign scan_end    = (idx == IDX_W'(NUM_UE - 1));
  assign cur         = stat[idx];
  assign ue_in_range = (32'(ue_id) < NUM_UE);

  // cell addressed: request target, scan position, or cell 0 to seed the token
  always_comb begin
    for (int i = 0; i < NUM_UE; i++) begin
      if (state == ST_IDLE) begin
        sel[i] = (opcode == OP_TICK) ? (i == 0) : (ue_id == 4'(i));
      end else begin
        sel[i] = (idx == IDX_W'(i));
      end
    end
  end

  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_REQUEST: cmd.req_wr     = ue_in_range;
            OP_RESOLVE: cmd.ring_load  = (req_valid_vec != '0);
            OP_TICK:    cmd.tick_start = (pending_vec != '0) && (blk_limit != '0);
            default: ;
          endcase
        end
      end
      ST_RING: cmd.ring_shift = 1'b1;
      ST_RESP: begin
        if (slot_free && cur.req_valid) begin
          cmd.resp_take = 1'b1;
          out_load      = 1'b1;
        end
      end
      ST_TICK: begin
        cmd.tick_step = (blk_cnt != blk_limit) && (pending_vec != '0);
      end
      ST_GRANT: begin
        if (slot_free && (cur.blocks != '0)) begin
          cmd.grant_take = 1'b1;
          // zero-sized blocks grant nothing and are never reported
          out_load       = (bits_per_block != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      blk_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx     <= '0;
          blk_cnt <= '0;
          if (cmd.ring_load) begin
            state <= (NUM_UE > 1) ? ST_RING : ST_RESP;
          end else if (cmd.tick_start) begin
            state <= ST_TICK;
          end
        end
        // NUM_UE-1 shifts let every cell see every other stored request
        ST_RING: begin
          if (idx == IDX_W'(NUM_UE - 2)) begin
            idx   <= '0;
            state <= ST_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_RESP: begin
          if (slot_free) begin
            idx <= idx + 1'b1;
            if (scan_end) begin
              state <= ST_IDLE;
            end
          end
        end
        // token moves one cell a cycle, a block goes to the holder if it has bits
        ST_TICK: begin
          if (cmd.tick_step) begin
            if (served_vec != '0) begin
              blk_cnt <= blk_cnt + 1'b1;
            end
          end else begin
            idx   <= '0;
            state <= ST_GRANT;
          end
        end
        ST_GRANT: begin
          if (slot_free) begin
            idx <= idx + 1'b1;
            if (scan_end) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ue_id_out <= 4'(idx);
      if (state == ST_RESP) begin
        kind           <= KIND_RESPONSE;
        granted        <= !cur.collided;
        allocated_bits <= '0;
        last           <= ((req_valid_vec & later_vec) == '0);
      end else begin
        kind           <= KIND_GRANT;
        granted        <= 1'b0;
        allocated_bits <= {{(ALLOC_W-BLK_W){1'b0}}, cur.blocks} *
                          {{(ALLOC_W-BPB_W){1'b0}}, bits_per_block};
        last           <= ((blocks_vec & later_vec) == '0);
      end
    end
  end

  // ---------------------------------------------------------------- checks
  `URRS_ASSERT_NOW(a_token_onehot, state == ST_TICK, $onehot(token_vec))
  `URRS_ASSERT_NOW(a_grant_nonzero, out_valid && kind == KIND_GRANT, allocated_bits != '0)
  `URRS_ASSERT_NEXT(a_resolve_clears, state == ST_RESP && slot_free && scan_end,
                    req_valid_vec == '0)

endmodule
